>>> rtl/elat_pkg.sv
// Shared widths, command and status codes for the extent list address translator.
`timescale 1ns / 1ps

package elat_pkg;

    localparam int OFF_W   = 16;   // byte offset, length and result fields
    localparam int CNT_W   = 5;    // extent count register and walk index
    localparam int IDX_W   = 4;    // entry_index field
    localparam int START_W = 7;    // extent start block
    localparam int BLEN_W  = 8;    // extent block count
    localparam int ST_W    = 2;

    typedef logic [ST_W-1:0] status_t;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_BOUND = 2'd1;
    localparam status_t ST_LIST  = 2'd2;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_ACCESS = 1'b1;

endpackage

>>> rtl/elat_if.sv
// Request, result and configuration channel interfaces.
`timescale 1ns / 1ps

interface elat_req_if;
    logic                              valid;
    logic                              ready;
    logic                              command;
    logic [elat_pkg::IDX_W-1:0]        entry_index;
    logic [elat_pkg::START_W-1:0]      extent_start_block;
    logic [elat_pkg::BLEN_W-1:0]       extent_block_count;
    logic                              is_write;
    logic [elat_pkg::OFF_W-1:0]        byte_offset;
    logic [elat_pkg::OFF_W-1:0]        byte_length;

    modport source (
        output valid, command, entry_index, extent_start_block, extent_block_count,
               is_write, byte_offset, byte_length,
        input  ready
    );
    modport sink (
        input  valid, command, entry_index, extent_start_block, extent_block_count,
               is_write, byte_offset, byte_length,
        output ready
    );
endinterface

interface elat_rsp_if;
    logic                          valid;
    logic                          ready;
    elat_pkg::status_t             status;
    logic [elat_pkg::OFF_W-1:0]    physical_address;
    logic [elat_pkg::OFF_W-1:0]    buffer_offset;
    logic [elat_pkg::OFF_W-1:0]    segment_length;
    logic                          direction;
    logic                          last;

    modport source (
        output valid, status, physical_address, buffer_offset, segment_length,
               direction, last,
        input  ready
    );
    modport sink (
        input  valid, status, physical_address, buffer_offset, segment_length,
               direction, last,
        output ready
    );
endinterface

interface elat_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [elat_pkg::CNT_W-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> rtl/elat_table.sv
// Extent table: one write port, one registered read port.
`timescale 1ns / 1ps

module elat_table #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [ADDR_W-1:0]              wr_addr,
    input  logic [elat_pkg::START_W-1:0]   wr_start,
    input  logic [elat_pkg::BLEN_W-1:0]    wr_len,
    input  logic [ADDR_W-1:0]              rd_addr,
    output logic [elat_pkg::START_W-1:0]   rd_start,
    output logic [elat_pkg::BLEN_W-1:0]    rd_len
);

    logic [elat_pkg::START_W+elat_pkg::BLEN_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_start, wr_len};
        end
        {rd_start, rd_len} <= mem[rd_addr];
    end

endmodule

>>> rtl/extent_list_address_translator.sv
// Top level: extent table walk that splits a file access into storage segments.
`timescale 1ns / 1ps

// Loads, bounds errors and empty accesses give one beat each, in the cycle after
// they are taken. After an access is accepted, the walk visits table entries in
// order from slot 0 up to the last extent it touches (entries that end before the
// access start included), with an extra step that reports a list error when the
// walk runs off the end of the list; a stalled result side holds the walk at a
// segment or error step. The pace is set by the extent table, which delivers one
// entry per cycle from its single registered read port while no beat waits on
// the result side. Results sit in an output register, so a new command is taken
// in the cycle its predecessor's final beat is handed over.
module extent_list_address_translator #(
    parameter int MAX_EXTENTS    = 16,
    parameter int BLOCK_BYTES    = 512,
    parameter int STORAGE_BLOCKS = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    elat_req_if.sink    req,
    elat_rsp_if.source  rsp,
    elat_cfg_if.sink    cfg
);

    localparam int TBL_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int EXT_W = $clog2(255 * BLOCK_BYTES + 1);
    localparam int SUM_W = ((EXT_W > elat_pkg::OFF_W + 1) ? EXT_W : elat_pkg::OFF_W + 1) + 1;
    localparam logic [31:0] STORAGE_BYTES = 32'(STORAGE_BLOCKS * BLOCK_BYTES);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    logic                           state_reg, state_next;
    logic [elat_pkg::CNT_W-1:0]     count_reg;
    logic [elat_pkg::CNT_W-1:0]     e_reg, e_next;
    logic [SUM_W-1:0]               base_reg, base_next;
    logic [SUM_W-1:0]               cur_reg, cur_next;
    logic [elat_pkg::OFF_W-1:0]     rem_reg, rem_next;
    logic [elat_pkg::OFF_W-1:0]     done_reg, done_next;
    logic                           dir_reg, dir_next;

    logic                           out_valid_reg, out_valid_next;
    elat_pkg::status_t              out_status_reg, out_status_next;
    logic [elat_pkg::OFF_W-1:0]     out_pa_reg, out_pa_next;
    logic [elat_pkg::OFF_W-1:0]     out_bo_reg, out_bo_next;
    logic [elat_pkg::OFF_W-1:0]     out_sl_reg, out_sl_next;
    logic                           out_dir_reg, out_dir_next;
    logic                           out_last_reg, out_last_next;

    logic                           out_free;
    logic                           req_fire;
    logic                           wr_en;
    logic [elat_pkg::START_W-1:0]   rd_start;
    logic [elat_pkg::BLEN_W-1:0]    rd_len;
    logic [elat_pkg::CNT_W-1:0]     n_ext;
    logic [elat_pkg::OFF_W:0]       req_end;
    logic                           over;
    logic [SUM_W-1:0]               ext_bytes;
    logic [SUM_W-1:0]               ext_end;
    logic [SUM_W-1:0]               pos;
    logic [SUM_W-1:0]               avail;
    logic [elat_pkg::OFF_W-1:0]     seg;
    logic [elat_pkg::OFF_W-1:0]     rem_after;
    logic [elat_pkg::OFF_W-1:0]     start_bytes;
    logic                           in_list;
    logic                           skip;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign n_ext = (int'(count_reg) > MAX_EXTENTS) ? elat_pkg::CNT_W'(MAX_EXTENTS) : count_reg;

    assign wr_en = req_fire && (req.command == elat_pkg::CMD_LOAD)
                   && (int'(req.entry_index) < MAX_EXTENTS);

    elat_table #(
        .DEPTH  (MAX_EXTENTS),
        .ADDR_W (TBL_W)
    ) u_table (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (TBL_W'(req.entry_index)),
        .wr_start (req.extent_start_block),
        .wr_len   (req.extent_block_count),
        .rd_addr  (TBL_W'(e_next)),
        .rd_start (rd_start),
        .rd_len   (rd_len)
    );

    assign req_end = {1'b0, req.byte_offset} + {1'b0, req.byte_length};
    assign over    = 32'(req_end) > STORAGE_BYTES;

    // walk datapath for the entry read out of the table this cycle
    assign ext_bytes   = SUM_W'(SUM_W'(rd_len) * SUM_W'(BLOCK_BYTES));
    assign ext_end     = base_reg + ext_bytes;
    assign in_list     = e_reg < n_ext;
    assign skip        = ext_end <= cur_reg;
    assign pos         = cur_reg - base_reg;
    assign avail       = ext_end - cur_reg;
    assign seg         = (avail > SUM_W'(rem_reg)) ? rem_reg : avail[elat_pkg::OFF_W-1:0];
    assign rem_after   = rem_reg - seg;
    assign start_bytes = elat_pkg::OFF_W'(32'(rd_start) * BLOCK_BYTES);

    always_comb
    begin
        state_next      = state_reg;
        e_next          = e_reg;
        base_next       = base_reg;
        cur_next        = cur_reg;
        rem_next        = rem_reg;
        done_next       = done_reg;
        dir_next        = dir_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_pa_next     = out_pa_reg;
        out_bo_next     = out_bo_reg;
        out_sl_next     = out_sl_reg;
        out_dir_next    = out_dir_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                e_next = '0;
                if (req_fire)
                begin
                    dir_next        = req.is_write;
                    out_status_next = elat_pkg::ST_OK;
                    out_pa_next     = '0;
                    out_bo_next     = '0;
                    out_sl_next     = '0;
                    out_dir_next    = req.is_write;
                    out_last_next   = 1'b1;
                    if (req.command == elat_pkg::CMD_LOAD)
                    begin
                        out_valid_next = 1'b1;
                        out_dir_next   = 1'b0;
                    end
                    else if (over)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = elat_pkg::ST_BOUND;
                    end
                    else if (req.byte_length == '0)
                    begin
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_WALK;
                        base_next  = '0;
                        cur_next   = SUM_W'(req.byte_offset);
                        rem_next   = req.byte_length;
                        done_next  = '0;
                    end
                end
            end
            S_WALK:
            begin
                if (!in_list)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = elat_pkg::ST_LIST;
                        out_pa_next     = '0;
                        out_bo_next     = done_reg;
                        out_sl_next     = '0;
                        out_dir_next    = dir_reg;
                        out_last_next   = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
                else if (skip)
                begin
                    // extent ends at or before the current position
                    base_next = ext_end;
                    e_next    = e_reg + 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = elat_pkg::ST_OK;
                    out_pa_next     = start_bytes + pos[elat_pkg::OFF_W-1:0];
                    out_bo_next     = done_reg;
                    out_sl_next     = seg;
                    out_dir_next    = dir_reg;
                    out_last_next   = (rem_after == '0);
                    done_next       = done_reg + seg;
                    cur_next        = cur_reg + SUM_W'(seg);
                    rem_next        = rem_after;
                    if (rem_after == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // segment used the rest of this extent
                        base_next = ext_end;
                        e_next    = e_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                count_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg          <= e_next;
        base_reg       <= base_next;
        cur_reg        <= cur_next;
        rem_reg        <= rem_next;
        done_reg       <= done_next;
        dir_reg        <= dir_next;
        out_status_reg <= out_status_next;
        out_pa_reg     <= out_pa_next;
        out_bo_reg     <= out_bo_next;
        out_sl_reg     <= out_sl_next;
        out_dir_reg    <= out_dir_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = out_status_reg;
    assign rsp.physical_address = out_pa_reg;
    assign rsp.buffer_offset    = out_bo_reg;
    assign rsp.segment_length   = out_sl_reg;
    assign rsp.direction        = out_dir_reg;
    assign rsp.last             = out_last_reg;

    a_walk_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (rem_reg != '0))
        else $error("walk running with no bytes left");

    a_enter_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.command == elat_pkg::CMD_ACCESS) && !over
         && (req.byte_length != '0)) |=> (state_reg == S_WALK))
        else $error("non-empty access did not start a walk");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (e_reg <= n_ext))
        else $error("walk index past extent count");

    a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.command == elat_pkg::CMD_LOAD)) |=>
        (out_valid_reg && out_last_reg && (out_status_reg == elat_pkg::ST_OK)
         && (state_reg == S_IDLE)))
        else $error("load without single ok beat");

endmodule
